/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the matrix multiplier.
// No dependencies; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_HOLDS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed: property does not hold");
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("assertion failed: forbidden condition seen");
`else
`define ASSERT_HOLDS(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

/* hw/rtl/smm_pkg.sv */
// Package for the square matrix multiplier: sizes, payload types, saturation bounds.
// No dependencies.
`default_nettype none
package smm_pkg;

  localparam int DIM       = 4;
  localparam int FRAC_BITS = 16;

  localparam int IDX_W   = 2;
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int DEPTH   = 2 ** ADDR_W;
  localparam int VALUE_W = 32;
  localparam int PROD_W  = 2 * VALUE_W;
  localparam int ACC_W   = PROD_W + $clog2(DIM) + 1;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIM - 1);

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(2147483647);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  localparam logic MODE_LEFT  = 1'b0;
  localparam logic MODE_RIGHT = 1'b1;

  typedef struct packed {
    logic                      mode;
    logic [IDX_W-1:0]          row;
    logic [IDX_W-1:0]          col;
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } load_t;

  typedef struct packed {
    logic [IDX_W-1:0]          out_row;
    logic [IDX_W-1:0]          out_col;
    logic signed [VALUE_W-1:0] product;
    logic                      last_result;
  } result_t;

endpackage
`default_nettype wire

/* hw/rtl/square_matrix_multiply.sv */
// Square matrix multiplier: two element stores, MAC pipeline, result register.
// Depends on smm_pkg and assert_macros.svh.
//
// Usage:
//   load channel (load_valid/load_ready/load): each transaction writes one
//   element of the left (mode 0) or right (mode 1) matrix at (row, col);
//   indexes at or beyond DIM are dropped. A transaction with last set stores
//   its element and then starts the product run.
//   result channel (result_valid/result_ready/result): DIM*DIM transactions
//   in row-major order, last_result set on the final one.
//   Throughput: a run makes one multiply-accumulate per cycle while the
//   output does not stall, paced by the single read port of each element
//   store. load_ready is low while the run issues its reads.
//   Stall: while a result waits in the output register and result_ready is
//   low, the whole read/multiply/accumulate pipeline holds.
//   Reset: clears the run and pipeline valids; the stores keep no reset
//   and every element must be loaded before it is used in a run.
`default_nettype none
`include "assert_macros.svh"
module square_matrix_multiply
  import smm_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load_valid,
  output logic         load_ready,
  input  wire load_t   load,
  output logic         result_valid,
  input  wire logic    result_ready,
  output result_t      result
);

  logic signed [VALUE_W-1:0] left_mem  [DEPTH];
  logic signed [VALUE_W-1:0] right_mem [DEPTH];

  logic             running;
  logic [IDX_W-1:0] i_cnt, j_cnt, k_cnt;
  logic             adv;
  logic             load_fire;
  logic             issue_last;

  // stage 1: read data
  logic                      s1_valid, s1_first, s1_kend, s1_last;
  logic [IDX_W-1:0]          s1_i, s1_j;
  logic signed [VALUE_W-1:0] l_q, r_q;
  // stage 2: product
  logic                      s2_valid, s2_first, s2_kend, s2_last;
  logic [IDX_W-1:0]          s2_i, s2_j;
  logic signed [PROD_W-1:0]  prod;
  // stage 3: accumulator
  logic                      s3_done, s3_last;
  logic [IDX_W-1:0]          s3_i, s3_j;
  logic signed [ACC_W-1:0]   acc, acc_next;
  logic signed [PROD_W-1:0]  term;
  logic signed [VALUE_W-1:0] sat;

  assign adv        = !result_valid || result_ready;
  assign load_ready = !running;
  assign load_fire  = load_valid && load_ready;
  assign issue_last = (i_cnt == LAST_IDX) && (j_cnt == LAST_IDX) && (k_cnt == LAST_IDX);

  always_ff @(posedge clk) begin
    if (load_fire && load.row <= LAST_IDX && load.col <= LAST_IDX) begin
      if (load.mode == MODE_RIGHT) begin
        right_mem[{load.row, load.col}] <= load.value;
      end else begin
        left_mem[{load.row, load.col}] <= load.value;
      end
    end
    if (adv && running) begin
      l_q <= left_mem[{i_cnt, k_cnt}];
      r_q <= right_mem[{k_cnt, j_cnt}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      i_cnt   <= '0;
      j_cnt   <= '0;
      k_cnt   <= '0;
    end else if (load_fire && load.last) begin
      running <= 1'b1;
      i_cnt   <= '0;
      j_cnt   <= '0;
      k_cnt   <= '0;
    end else if (adv && running) begin
      if (issue_last) begin
        running <= 1'b0;
      end
      if (k_cnt == LAST_IDX) begin
        k_cnt <= '0;
        if (j_cnt == LAST_IDX) begin
          j_cnt <= '0;
          i_cnt <= i_cnt + IDX_W'(1);
        end else begin
          j_cnt <= j_cnt + IDX_W'(1);
        end
      end else begin
        k_cnt <= k_cnt + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_done  <= 1'b0;
    end else if (adv) begin
      s1_valid <= running;
      s2_valid <= s1_valid;
      s3_done  <= s2_valid && s2_kend;
    end
  end

  assign term     = prod >>> FRAC_BITS;
  assign acc_next = (s2_first ? '0 : acc) + ACC_W'(term);

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_first <= (k_cnt == '0);
      s1_kend  <= (k_cnt == LAST_IDX);
      s1_last  <= issue_last;
      s1_i     <= i_cnt;
      s1_j     <= j_cnt;
      prod     <= PROD_W'(l_q) * PROD_W'(r_q);
      s2_first <= s1_first;
      s2_kend  <= s1_kend;
      s2_last  <= s1_last;
      s2_i     <= s1_i;
      s2_j     <= s1_j;
      if (s2_valid) begin
        acc <= acc_next;
      end
      s3_last  <= s2_last;
      s3_i     <= s2_i;
      s3_j     <= s2_j;
    end
  end

  always_comb begin
    if (acc > SAT_HI) begin
      sat = VALUE_W'(SAT_HI);
    end else if (acc < SAT_LO) begin
      sat = VALUE_W'(SAT_LO);
    end else begin
      sat = VALUE_W'(acc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= s3_done;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s3_done) begin
      result.out_row     <= s3_i;
      result.out_col     <= s3_j;
      result.product     <= sat;
      result.last_result <= s3_last;
    end
  end

  `ASSERT_HOLDS(a_start_run, clk, rst, load_fire && load.last |=> running)
  `ASSERT_HOLDS(a_run_ends_on_last, clk, rst, $fell(running) |-> s1_valid && s1_last)
  `ASSERT_HOLDS(a_stall_holds_acc, clk, rst, result_valid && !result_ready |=> $stable(acc))
  `ASSERT_HOLDS(a_last_corner, clk, rst,
    result_valid && result.last_result |->
      result.out_row == LAST_IDX && result.out_col == LAST_IDX)

endmodule
`default_nettype wire
